// ===== sv/mosaic_pixelate_filter_defines.svh =====
`ifndef MOSAIC_PIXELATE_FILTER_DEFINES_SVH
`define MOSAIC_PIXELATE_FILTER_DEFINES_SVH

// Same-cycle and next-cycle implication checks on clk, quiet during rst.
`ifndef SYNTHESIS
`define MPF_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mosaic filter check failed");
`define MPF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mosaic filter check failed");
`else
`define MPF_ASSERT_SAME(lbl, pre, post)
`define MPF_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== sv/mpf_pkg.sv =====
`timescale 1ns / 1ps
package mpf_pkg;

  localparam int COLOR_W = 32;
  localparam int CHUNK_W = 8;
  localparam int CFG_W = 11;
  localparam int ROW_W = 10;
  localparam int MAX_HEIGHT = 1024;
  localparam int REG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_CHUNK_MAX = 255;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [CHUNK_W-1:0] RST_START_CHUNK = 8'd8;
  localparam logic [CHUNK_W-1:0] CHUNK_STEP = 8'd2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_CHUNK = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_GROW_OUT = 2'd3;

  localparam logic [1:0] SEL_HOLD = 2'd0;
  localparam logic [1:0] SEL_PIXEL = 2'd1;
  localparam logic [1:0] SEL_STORE = 2'd2;

  typedef struct packed {
    logic first_col;
    logic first_row;
    logic last;
    logic [CHUNK_W-1:0] chunk;
  } pix_ctl_t;

  function automatic logic [CHUNK_W-1:0] clamp_chunk(input logic [CHUNK_W-1:0] v,
                                                     input logic [CHUNK_W-1:0] hi);
    return (v == '0) ? CHUNK_W'(1) : ((v > hi) ? hi : v);
  endfunction

endpackage

// ===== sv/mpf_line_store.sv =====
`timescale 1ns / 1ps
module mpf_line_store #(
  parameter int DEPTH = mpf_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [AW-1:0]                addr,
  input  logic [mpf_pkg::COLOR_W-1:0]  wdata,
  output logic [mpf_pkg::COLOR_W-1:0]  rdata
);

  logic [mpf_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/mpf_seq.sv =====
`timescale 1ns / 1ps
module mpf_seq #(
  parameter int MAX_WIDTH = mpf_pkg::DEF_MAX_WIDTH,
  parameter int CHUNK_MAX = mpf_pkg::DEF_CHUNK_MAX,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mpf_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [mpf_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            adv,
  output mpf_pkg::pix_ctl_t               ctl,
  output logic [CW-1:0]                   slot
);

  localparam logic [mpf_pkg::CHUNK_W-1:0] CMAX = mpf_pkg::CHUNK_W'(CHUNK_MAX);

  logic [mpf_pkg::CFG_W-1:0]   frame_width;
  logic [mpf_pkg::CFG_W-1:0]   frame_height;
  logic [mpf_pkg::CHUNK_W-1:0] start_chunk;
  logic                        grow_out;

  logic [CW-1:0]                column_count, column_count_next;
  logic [mpf_pkg::ROW_W-1:0]    row_count, row_count_next;
  logic [mpf_pkg::CHUNK_W-1:0]  column_in_block, column_in_block_next;
  logic [mpf_pkg::CHUNK_W-1:0]  row_in_block, row_in_block_next;
  logic [CW-1:0]                block_column, block_column_next;
  logic [mpf_pkg::CHUNK_W-1:0]  current_chunk, current_chunk_next;

  logic [CW:0]                  w, col_inc;
  logic [mpf_pkg::ROW_W:0]      h, row_inc;
  logic [mpf_pkg::CHUNK_W:0]    cib_inc, rib_inc, grow_sum;
  logic                         line_end, frame_end, blk_end;

  always_comb begin
    if (frame_width == '0) begin
      w = (CW+1)'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w = (CW+1)'(MAX_WIDTH);
    end else begin
      w = (CW+1)'(frame_width);
    end
    if (frame_height == '0) begin
      h = (mpf_pkg::ROW_W+1)'(1);
    end else if (32'(frame_height) > 32'(mpf_pkg::MAX_HEIGHT)) begin
      h = (mpf_pkg::ROW_W+1)'(mpf_pkg::MAX_HEIGHT);
    end else begin
      h = (mpf_pkg::ROW_W+1)'(frame_height);
    end
  end

  assign col_inc = {1'b0, column_count} + (CW+1)'(1);
  assign row_inc = {1'b0, row_count} + (mpf_pkg::ROW_W+1)'(1);
  assign cib_inc = {1'b0, column_in_block} + 9'd1;
  assign rib_inc = {1'b0, row_in_block} + 9'd1;
  assign grow_sum = {1'b0, current_chunk} + {1'b0, mpf_pkg::CHUNK_STEP};

  assign line_end = col_inc >= w;
  assign frame_end = line_end && (row_inc >= h);
  assign blk_end = cib_inc >= {1'b0, current_chunk};

  always_comb begin
    column_count_next = line_end ? '0 : col_inc[CW-1:0];
    column_in_block_next = (line_end || blk_end) ? '0 : cib_inc[mpf_pkg::CHUNK_W-1:0];
    if (line_end) begin
      block_column_next = '0;
    end else if (blk_end) begin
      block_column_next = block_column + CW'(1);
    end else begin
      block_column_next = block_column;
    end
    if (frame_end) begin
      row_count_next = '0;
      row_in_block_next = '0;
    end else if (line_end) begin
      row_count_next = row_inc[mpf_pkg::ROW_W-1:0];
      row_in_block_next = (rib_inc >= {1'b0, current_chunk}) ? '0
                          : rib_inc[mpf_pkg::CHUNK_W-1:0];
    end else begin
      row_count_next = row_count;
      row_in_block_next = row_in_block;
    end
    if (!frame_end) begin
      current_chunk_next = current_chunk;
    end else if (grow_out) begin
      current_chunk_next = (grow_sum > {1'b0, CMAX}) ? CMAX
                           : grow_sum[mpf_pkg::CHUNK_W-1:0];
    end else begin
      current_chunk_next = (current_chunk <= mpf_pkg::CHUNK_STEP) ? 8'd1
                           : current_chunk - mpf_pkg::CHUNK_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= mpf_pkg::RST_FRAME_WIDTH;
      frame_height <= mpf_pkg::RST_FRAME_HEIGHT;
      start_chunk <= mpf_pkg::RST_START_CHUNK;
      grow_out <= 1'b0;
      column_count <= '0;
      row_count <= '0;
      column_in_block <= '0;
      row_in_block <= '0;
      block_column <= '0;
      current_chunk <= mpf_pkg::clamp_chunk(mpf_pkg::RST_START_CHUNK, CMAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpf_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data;
        mpf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        mpf_pkg::REG_START_CHUNK: start_chunk <= cfg_data[mpf_pkg::CHUNK_W-1:0];
        mpf_pkg::REG_GROW_OUT: grow_out <= cfg_data[0];
        default: ;
      endcase
      if (cfg_index != mpf_pkg::REG_GROW_OUT) begin
        column_count <= '0;
        row_count <= '0;
        column_in_block <= '0;
        row_in_block <= '0;
        block_column <= '0;
        current_chunk <= mpf_pkg::clamp_chunk(
            (cfg_index == mpf_pkg::REG_START_CHUNK) ? cfg_data[mpf_pkg::CHUNK_W-1:0]
                                                    : start_chunk, CMAX);
      end
    end else if (adv) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
      column_in_block <= column_in_block_next;
      row_in_block <= row_in_block_next;
      block_column <= block_column_next;
      current_chunk <= current_chunk_next;
    end
  end

  assign ctl.first_col = column_in_block == '0;
  assign ctl.first_row = row_in_block == '0;
  assign ctl.last = frame_end;
  assign ctl.chunk = current_chunk;
  assign slot = block_column;

endmodule

// ===== sv/mosaic_pixelate_filter.sv =====
`timescale 1ns / 1ps
// channel   signals                               width
// ------    ------------------------------------  -------------
// in        in_valid in_ready in_color            32
// out       out_valid out_ready out_color         32
//           frame_last chunk_used                 1, 8
// cfg       cfg_we cfg_index cfg_data             1, 2, 11
//
// One pixel a cycle while out_ready is high; stage one feeds the output register.
// The line store read issues on the input beat and its data is registered.
// rst is synchronous; chunk reloads from start_chunk (8 after reset).
// out_ready low fills the output register and then stage one, then in_ready drops.
`include "mosaic_pixelate_filter_defines.svh"
module mosaic_pixelate_filter #(
  parameter int MAX_WIDTH = mpf_pkg::DEF_MAX_WIDTH,
  parameter int CHUNK_MAX = mpf_pkg::DEF_CHUNK_MAX
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mpf_pkg::COLOR_W-1:0]     in_color,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpf_pkg::COLOR_W-1:0]     out_color,
  output logic                            frame_last,
  output logic [mpf_pkg::CHUNK_W-1:0]     chunk_used,
  input  logic                            cfg_we,
  input  logic [mpf_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [mpf_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  mpf_pkg::pix_ctl_t            ctl;
  logic [CW-1:0]                slot;
  logic                         in_fire, out_free, s1_adv, mem_we, mem_re;
  logic [mpf_pkg::COLOR_W-1:0]  rd_data, color_next;

  logic                         s1_valid;
  logic [1:0]                   s1_sel;
  logic [mpf_pkg::COLOR_W-1:0]  s1_pixel;
  logic                         s1_last;
  logic [mpf_pkg::CHUNK_W-1:0]  s1_chunk;

  assign out_free = !out_valid || out_ready;
  assign s1_adv = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign in_fire = in_valid && in_ready;
  assign mem_we = in_fire && ctl.first_col && ctl.first_row;
  assign mem_re = in_fire && ctl.first_col && !ctl.first_row;

  mpf_seq #(
    .MAX_WIDTH(MAX_WIDTH),
    .CHUNK_MAX(CHUNK_MAX)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .adv(in_fire),
    .ctl(ctl),
    .slot(slot)
  );

  mpf_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_store (
    .clk(clk),
    .we(mem_we),
    .re(mem_re),
    .addr(slot),
    .wdata(in_color),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sel <= !ctl.first_col ? mpf_pkg::SEL_HOLD
              : (ctl.first_row ? mpf_pkg::SEL_PIXEL : mpf_pkg::SEL_STORE);
      s1_pixel <= in_color;
      s1_last <= ctl.last;
      s1_chunk <= ctl.chunk;
    end
  end

  always_comb begin
    case (s1_sel)
      mpf_pkg::SEL_PIXEL: color_next = s1_pixel;
      mpf_pkg::SEL_STORE: color_next = rd_data;
      default: color_next = out_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // out_color doubles as the held block color
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_color <= color_next;
      frame_last <= s1_last;
      chunk_used <= s1_chunk;
    end
  end

  `MPF_ASSERT_NEXT(a_restart_after_last, in_fire && ctl.last, ctl.first_col && ctl.first_row)
  `MPF_ASSERT_NEXT(a_chunk_steady, in_fire && !ctl.last && !cfg_we, ctl.chunk == $past(ctl.chunk))
  `MPF_ASSERT_SAME(a_chunk_range, out_valid, chunk_used != '0 && chunk_used <= CHUNK_MAX)
  `MPF_ASSERT_NEXT(a_read_kept, s1_valid && !out_free && s1_sel == mpf_pkg::SEL_STORE, $stable(rd_data))

endmodule
